[rtl/cle_pkg.sv]
// Shared types and key codes of the console line editor.
`default_nettype none
package cle_pkg;

   localparam logic [7:0] KEY_ERASE_A = 8'h08;
   localparam logic [7:0] KEY_ERASE_B = 8'h7f;
   localparam logic [7:0] KEY_CR      = 8'h0d;
   localparam logic [7:0] KEY_LF      = 8'h0a;
   localparam logic [7:0] KEY_DUMP    = 8'h10;
   localparam logic [7:0] KEY_KILL    = 8'h15;
   localparam logic [7:0] KEY_HOT1    = 8'h03;
   localparam logic [7:0] KEY_HOT2    = 8'h0f;
   localparam logic [7:0] KEY_HOT3    = 8'h0c;
   localparam logic [7:0] KEY_EOF     = 8'h04;
   localparam logic [7:0] KEY_NUL     = 8'h00;

   localparam int QDEPTH = 2;

   typedef enum logic [3:0] {
      OP_NOP    = 4'd0,
      OP_INSERT = 4'd1,
      OP_ERASE  = 4'd2,
      OP_KILL   = 4'd3,
      OP_HOT1   = 4'd4,
      OP_HOT2   = 4'd5,
      OP_HOT3   = 4'd6,
      OP_DUMP   = 4'd7,
      OP_READ   = 4'd8
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] ch;
      logic       first;
   } qword_type;

   // lowest bit last
   typedef struct packed {
      logic       read_empty;
      logic       read_eof;
      logic [7:0] read_char;
      logic       read_valid;
      logic       menu_open;
      logic       menu_toggled;
      logic       dump_request;
      logic       line_ready;
      logic [7:0] erase_count;
      logic [7:0] echo_char;
      logic       echo_valid;
   } rsp_type;

endpackage
`default_nettype wire

[rtl/console_line_editor.sv]
// Top level of the console line editor.
//
// Request channel (req_): one word per keystroke (req_tuser 0) or per read
// of one committed byte (req_tuser 1). Response channel (rsp_): exactly one
// word per request, in request order.
// The front end decodes requests into a two-entry queue; the back end owns
// the line store (a BUF_DEPTH x 8 RAM with registered read) and the indices.
// A read that finds a committed byte waits on the store's registered read
// before it completes. A kill walks back entry by entry and stops at the
// commit point or at a line end; each step of that walk waits on the
// store's registered read. The back end takes no new word from the queue
// until the current one has been handed to the response register.
// Reset empties the store, clears all indices, hotkey progress and the menu
// flag, and drops any queued or pending words. A stalled rsp_tready holds
// the response; the queue keeps taking requests until it fills.
`default_nettype none
module console_line_editor import cle_pkg::*; #(
   parameter int BUF_DEPTH = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic        req_tuser,  // func
   input  wire logic [15:0] req_tdata,  // key_code[7:0], first_of_read[8], zero pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // echo_valid, echo_char, erase_count, line_ready, dump_request,
   // menu_toggled, menu_open, read_valid, read_char, read_eof, read_empty
   output logic [31:0]      rsp_tdata
);

   logic      q_push, q_full, q_pop, q_empty;
   qword_type q_in_word, q_out_word;
   rsp_type   rsp_word;

   cle_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_word     (q_in_word)
   );

   cle_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (q_in_word),
      .full      (q_full),
      .pop       (q_pop),
      .pop_word  (q_out_word),
      .empty     (q_empty)
   );

   cle_back #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_word     (q_out_word),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_word   (rsp_word)
   );

   assign rsp_tdata = rsp_word;

endmodule
`default_nettype wire

[rtl/cle_ram.sv]
// Generic single-port-write, registered-read RAM.
`default_nettype none
module cle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/cle_front.sv]
// Front end: accepts request words and decodes them into queue operations.
`default_nettype none
module cle_front import cle_pkg::*; (
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic        req_tuser,
   input  wire logic [15:0] req_tdata,
   input  wire logic        q_full,
   output logic             q_push,
   output qword_type        q_word
);

   logic [7:0] key;

   assign key        = req_tdata[7:0];
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      q_word.ch    = key;
      q_word.first = req_tdata[8];
      q_word.op    = OP_INSERT;
      if (req_tuser) begin
         q_word.op = OP_READ;
      end else begin
         case (key)
            KEY_NUL:                  q_word.op = OP_NOP;
            KEY_DUMP:                 q_word.op = OP_DUMP;
            KEY_KILL:                 q_word.op = OP_KILL;
            KEY_ERASE_A, KEY_ERASE_B: q_word.op = OP_ERASE;
            KEY_HOT1:                 q_word.op = OP_HOT1;
            KEY_HOT2:                 q_word.op = OP_HOT2;
            KEY_HOT3:                 q_word.op = OP_HOT3;
            KEY_CR: begin
               q_word.op = OP_INSERT;
               q_word.ch = KEY_LF;
            end
            default:                  q_word.op = OP_INSERT;
         endcase
      end
   end

endmodule
`default_nettype wire

[rtl/cle_fifo.sv]
// Short register queue between front and back ends.
`default_nettype none
module cle_fifo import cle_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire qword_type push_word,
   output logic           full,
   input  wire logic      pop,
   output qword_type      pop_word,
   output logic           empty
);

   localparam int PW = $clog2(QDEPTH);
   localparam int CW = $clog2(QDEPTH + 1);

   qword_type         mem_ff [QDEPTH];
   logic [PW-1:0]     wp_ff, wp_in;
   logic [PW-1:0]     rp_ff, rp_in;
   logic [CW-1:0]     cnt_ff, cnt_in;

   assign full     = (cnt_ff == CW'(QDEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_word = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == PW'(QDEPTH - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (pop) begin
         rp_in = (rp_ff == PW'(QDEPTH - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= push_word;
      end
   end

endmodule
`default_nettype wire

[rtl/cle_back.sv]
// Back end: line store, indices, hotkey tracking and the result register.
`default_nettype none
module cle_back import cle_pkg::*; #(
   parameter int BUF_DEPTH = 128
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      q_empty,
   input  wire qword_type q_word,
   output logic           q_pop,
   output logic           rsp_tvalid,
   input  wire logic      rsp_tready,
   output rsp_type        rsp_word
);

   localparam int IW      = $clog2(2 * BUF_DEPTH);
   localparam int SW      = $clog2(BUF_DEPTH);
   localparam int IDX_MOD = 2 * BUF_DEPTH;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_EXEC     = 6'b000010,
      ST_KILL_RD  = 6'b000100,
      ST_KILL_CMP = 6'b001000,
      ST_READ_CMP = 6'b010000,
      ST_DONE     = 6'b100000
   } state_type;

   function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] a);
      return (a == IW'(IDX_MOD - 1)) ? '0 : a + 1'b1;
   endfunction

   function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] a);
      return (a == '0) ? IW'(IDX_MOD - 1) : a - 1'b1;
   endfunction

   function automatic logic [IW-1:0] idx_half(input logic [IW-1:0] a);
      return (a >= IW'(BUF_DEPTH)) ? a - IW'(BUF_DEPTH) : a + IW'(BUF_DEPTH);
   endfunction

   function automatic logic [SW-1:0] slot(input logic [IW-1:0] a);
      logic [IW-1:0] s;
      s = (a >= IW'(BUF_DEPTH)) ? a - IW'(BUF_DEPTH) : a;
      return s[SW-1:0];
   endfunction

   function automatic logic [7:0] sat8(input logic [IW-1:0] n);
      logic [15:0] w;
      w = 16'(n);
      return (w > 16'd255) ? 8'hff : w[7:0];
   endfunction

   state_type     state_ff, state_in;
   qword_type     cur_ff, cur_in;
   logic [IW-1:0] rd_ff, rd_in;
   logic [IW-1:0] cm_ff, cm_in;
   logic [IW-1:0] ed_ff, ed_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic [1:0]    hot_ff, hot_in;
   logic          menu_ff, menu_in;
   rsp_type       res_ff, res_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          ram_we, ram_re;
   logic [SW-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_rdata;
   logic [IW:0]   used;
   logic [IW-1:0] ed_next;

   cle_ram #(
      .WIDTH (8),
      .DEPTH (BUF_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (cur_ff.ch),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign used = (ed_ff >= rd_ff) ? {1'b0, ed_ff} - {1'b0, rd_ff}
                                  : {1'b0, ed_ff} + (IW+1)'(IDX_MOD) - {1'b0, rd_ff};
   assign ed_next = idx_inc(ed_ff);

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      rd_in        = rd_ff;
      cm_in        = cm_ff;
      ed_in        = ed_ff;
      cnt_in       = cnt_ff;
      hot_in       = hot_ff;
      menu_in      = menu_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_waddr    = slot(ed_ff);
      ram_raddr    = slot(rd_ff);

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cur_in   = q_word;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_in           = '0;
            res_in.menu_open = menu_ff;
            state_in         = ST_DONE;
            case (cur_ff.op)
               OP_DUMP: res_in.dump_request = !menu_ff;
               OP_KILL: begin
                  cnt_in   = '0;
                  state_in = ST_KILL_RD;
               end
               OP_ERASE: begin
                  if (ed_ff != cm_ff) begin
                     ed_in              = idx_dec(ed_ff);
                     res_in.erase_count = 8'd1;
                  end
               end
               OP_HOT1: hot_in = (hot_ff == 2'd0) ? 2'd1 : 2'd0;
               OP_HOT2: hot_in = (hot_ff == 2'd1) ? 2'd2 : 2'd0;
               OP_HOT3: begin
                  hot_in = 2'd0;
                  if (hot_ff == 2'd2) begin
                     menu_in             = !menu_ff;
                     res_in.menu_toggled = 1'b1;
                     res_in.menu_open    = !menu_ff;
                  end
               end
               OP_INSERT: begin
                  if (used < (IW+1)'(BUF_DEPTH)) begin
                     ram_we            = 1'b1;
                     ed_in             = ed_next;
                     res_in.echo_valid = 1'b1;
                     res_in.echo_char  = cur_ff.ch;
                     if ((cur_ff.ch == KEY_LF || cur_ff.ch == KEY_EOF ||
                          ed_next == idx_half(rd_ff)) && !menu_ff) begin
                        cm_in             = ed_next;
                        res_in.line_ready = 1'b1;
                     end
                  end
               end
               OP_READ: begin
                  if (rd_ff == cm_ff) begin
                     res_in.read_empty = 1'b1;
                  end else begin
                     ram_re   = 1'b1;
                     state_in = ST_READ_CMP;
                  end
               end
               default: ;
            endcase
         end
         ST_KILL_RD: begin
            ram_raddr = slot(idx_dec(ed_ff));
            if (ed_ff == cm_ff) begin
               res_in.erase_count = sat8(cnt_ff);
               state_in           = ST_DONE;
            end else begin
               ram_re   = 1'b1;
               state_in = ST_KILL_CMP;
            end
         end
         ST_KILL_CMP: begin
            if (ram_rdata == KEY_LF) begin
               res_in.erase_count = sat8(cnt_ff);
               state_in           = ST_DONE;
            end else begin
               ed_in    = idx_dec(ed_ff);
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_KILL_RD;
            end
         end
         ST_READ_CMP: begin
            state_in = ST_DONE;
            if (ram_rdata == KEY_EOF) begin
               res_in.read_eof = 1'b1;
               if (cur_ff.first) begin
                  rd_in = idx_inc(rd_ff);
               end
            end else begin
               rd_in             = idx_inc(rd_ff);
               res_in.read_valid = 1'b1;
               res_in.read_char  = ram_rdata;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_ff        <= '0;
         cm_ff        <= '0;
         ed_ff        <= '0;
         hot_ff       <= '0;
         menu_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ff        <= rd_in;
         cm_ff        <= cm_in;
         ed_ff        <= ed_in;
         hot_ff       <= hot_in;
         menu_ff      <= menu_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff <= cur_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_word   = rsp_ff;

endmodule
`default_nettype wire

[rtl/cle_checker.sv]
// Port-level assertions for the console line editor, bound to the top level.
`default_nettype none
module cle_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response word dropped while stalled");

   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response word changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_read_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0({rsp_tdata[21], rsp_tdata[30], rsp_tdata[31]}) &&
                     !(rsp_tdata[0] && (rsp_tdata[21] || rsp_tdata[30] || rsp_tdata[31])))
      else $error("read outcome flags inconsistent");

   a_echo_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[8:1] == 8'h00)
      else $error("echo character without echo");

endmodule

bind console_line_editor cle_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

[dv/tb_console_line_editor.sv]
// Self-checking testbench for the console line editor: directed and random keystrokes and reads.
module tb_console_line_editor;
   import cle_pkg::*;

   localparam int BUF_DEPTH   = 128;
   localparam int IW          = $clog2(2 * BUF_DEPTH);
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int WORD_TARGET = 1000;

   typedef logic [IW-1:0] idx_t;

   // line discipline predictor plus the queue of responses still owed
   class line_discipline_model;
      logic [7:0] text [BUF_DEPTH];
      idx_t       rd_idx;
      idx_t       cm_idx;
      idx_t       ed_idx;
      bit [1:0]   hot_step;
      bit         menu;
      rsp_type    responses_due [$];
      int         errors;

      function new();
         rd_idx   = '0;
         cm_idx   = '0;
         ed_idx   = '0;
         hot_step = '0;
         menu     = 1'b0;
         errors   = 0;
      endfunction

      function void note_request(bit func, logic [7:0] key, bit first);
         rsp_type    r;
         int         erased;
         idx_t       used;
         logic [7:0] c;
         r      = '0;
         erased = 0;
         if (!func) begin
            case (key)
               KEY_DUMP: begin
                  if (!menu) r.dump_request = 1'b1;
               end
               KEY_KILL: begin
                  while (ed_idx != cm_idx &&
                         text[idx_t'(ed_idx - 1) % BUF_DEPTH] != KEY_LF) begin
                     ed_idx = idx_t'(ed_idx - 1);
                     erased++;
                  end
               end
               KEY_ERASE_A, KEY_ERASE_B: begin
                  if (ed_idx != cm_idx) begin
                     ed_idx = idx_t'(ed_idx - 1);
                     erased = 1;
                  end
               end
               KEY_HOT1: hot_step = (hot_step == 2'd0) ? 2'd1 : 2'd0;
               KEY_HOT2: hot_step = (hot_step == 2'd1) ? 2'd2 : 2'd0;
               KEY_HOT3: begin
                  if (hot_step == 2'd2) begin
                     menu           = !menu;
                     r.menu_toggled = 1'b1;
                  end
                  hot_step = 2'd0;
               end
               KEY_NUL: ;
               default: begin
                  used = idx_t'(ed_idx - rd_idx);
                  if (used < BUF_DEPTH) begin
                     c                        = (key == KEY_CR) ? KEY_LF : key;
                     text[ed_idx % BUF_DEPTH] = c;
                     ed_idx                   = idx_t'(ed_idx + 1);
                     r.echo_valid             = 1'b1;
                     r.echo_char              = c;
                     if ((c == KEY_LF || c == KEY_EOF ||
                          ed_idx == idx_t'(rd_idx + BUF_DEPTH)) && !menu) begin
                        cm_idx       = ed_idx;
                        r.line_ready = 1'b1;
                     end
                  end
               end
            endcase
            r.erase_count = (erased > 255) ? 8'd255 : 8'(erased);
         end else begin
            if (rd_idx == cm_idx) begin
               r.read_empty = 1'b1;
            end else begin
               c = text[rd_idx % BUF_DEPTH];
               if (c == KEY_EOF) begin
                  r.read_eof = 1'b1;
                  if (first) rd_idx = idx_t'(rd_idx + 1);
               end else begin
                  rd_idx      = idx_t'(rd_idx + 1);
                  r.read_valid = 1'b1;
                  r.read_char  = c;
               end
            end
         end
         r.menu_open = menu;
         responses_due.push_back(r);
      endfunction

      function void compare_field(string name, int e, int a);
         if (e != a) begin
            $error("%s: expected 'h%0h, got 'h%0h", name, e, a);
            errors++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (responses_due.size() == 0) begin
            $error("response word with none outstanding: 'h%0h", got);
            errors++;
            return;
         end
         e = responses_due.pop_front();
         compare_field("echo_valid",   e.echo_valid,   got.echo_valid);
         compare_field("echo_char",    e.echo_char,    got.echo_char);
         compare_field("erase_count",  e.erase_count,  got.erase_count);
         compare_field("line_ready",   e.line_ready,   got.line_ready);
         compare_field("dump_request", e.dump_request, got.dump_request);
         compare_field("menu_toggled", e.menu_toggled, got.menu_toggled);
         compare_field("menu_open",    e.menu_open,    got.menu_open);
         compare_field("read_valid",   e.read_valid,   got.read_valid);
         compare_field("read_char",    e.read_char,    got.read_char);
         compare_field("read_eof",     e.read_eof,     got.read_eof);
         compare_field("read_empty",   e.read_empty,   got.read_empty);
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic        req_tuser  = 1'b0;
   logic [15:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   line_discipline_model model;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int words_sent  = 0;
   int cycle_count = 0;

   console_line_editor #(.BUF_DEPTH(BUF_DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) model.check_response(rsp_type'(rsp_tdata));
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic send_word(input bit func, input logic [7:0] key, input bit first);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {7'b0, first, key};
      do @(posedge clock); while (!req_tready);
      model.note_request(func, key, first);
      if (func || key != KEY_NUL) words_sent++;
   endtask

   task automatic send_key(input logic [7:0] key);
      send_word(1'b0, key, 1'($urandom_range(0, 1)));
   endtask

   task automatic send_read(input bit first);
      send_word(1'b1, 8'($urandom_range(0, 255)), first);
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (model.responses_due.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] text_char();
      if ($urandom_range(0, 9) < 7) return 8'($urandom_range(8'h20, 8'h7e));
      return 8'($urandom_range(0, 255));
   endfunction

   // printable only, so the store fills without a commit on a line end
   task automatic fill_store();
      repeat (BUF_DEPTH + 4) send_key(8'($urandom_range(8'h20, 8'h7e)));
   endtask

   task automatic random_sequence();
      int kind;
      int n;
      logic [7:0] hot [4];
      kind = $urandom_range(0, 99);
      hot  = '{KEY_HOT1, KEY_HOT2, KEY_HOT3, 8'h41};
      if (kind < 45) begin
         n = $urandom_range(1, 12);
         for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0)
               send_key($urandom_range(0, 1) ? KEY_ERASE_A : KEY_ERASE_B);
            else
               send_key(text_char());
         end
         case ($urandom_range(0, 3))
            0:       send_key(KEY_CR);
            3:       send_key(KEY_EOF);
            default: send_key(KEY_LF);
         endcase
         n = n + $urandom_range(0, 2);
         for (int k = 0; k < n; k++) send_read(k == 0 || $urandom_range(0, 9) == 0);
      end else if (kind < 57) begin
         repeat ($urandom_range(1, 6)) send_read(1'($urandom_range(0, 1)));
      end else if (kind < 67) begin
         if ($urandom_range(0, 9) < (model.menu ? 9 : 5)) begin
            send_key(KEY_HOT1);
            send_key(KEY_HOT2);
            send_key(KEY_HOT3);
         end else begin
            repeat (3) send_key(hot[$urandom_range(0, 3)]);
         end
      end else if (kind < 75) begin
         repeat ($urandom_range(0, 10)) send_key(text_char());
         send_key(KEY_KILL);
         repeat ($urandom_range(0, 3)) send_key(text_char());
      end else if (kind < 80) begin
         send_key(KEY_DUMP);
         send_key($urandom_range(0, 1) ? KEY_ERASE_A : KEY_ERASE_B);
      end else if (kind == 80) begin
         fill_store();
         if ($urandom_range(0, 1))
            send_key(KEY_KILL);
         else
            repeat (BUF_DEPTH + 2) send_read(1'b1);
      end else if (kind < 84) begin
         drain_responses();
      end else begin
         send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      model = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      tx_idle_pct = 24;
      rx_idle_pct = 81;

      // directed: empty reads and edits, line ends, EOF handling, menu hotkeys
      send_read(1'b1);
      send_key(KEY_ERASE_A);
      send_key(KEY_KILL);
      send_key(KEY_NUL);
      send_key(8'h61);
      send_key(8'hff);
      send_key(8'h80);
      send_key(KEY_ERASE_B);
      send_key(KEY_CR);
      send_read(1'b1);
      send_read(1'b0);
      send_read(1'b0);
      send_key(8'h78);
      send_key(KEY_EOF);
      send_read(1'b1);
      send_read(1'b0);
      send_read(1'b1);
      send_read(1'b1);
      send_key(KEY_DUMP);
      send_key(KEY_HOT1);
      send_key(KEY_HOT2);
      send_key(KEY_HOT3);
      send_key(KEY_DUMP);
      send_key(8'h71);
      send_key(KEY_LF);
      send_key(KEY_HOT1);
      send_key(KEY_HOT1);
      send_key(KEY_HOT2);
      send_key(KEY_HOT3);
      send_key(KEY_HOT1);
      send_key(KEY_HOT2);
      send_key(KEY_HOT3);
      send_key(8'h7a);
      send_key(KEY_KILL);

      // full store: commit on full and dropped keys, then drain
      fill_store();
      repeat (BUF_DEPTH + 2) send_read(1'b1);
      // full store with the menu open, then kill it all
      send_key(KEY_HOT1);
      send_key(KEY_HOT2);
      send_key(KEY_HOT3);
      fill_store();
      send_key(KEY_KILL);
      send_key(KEY_HOT1);
      send_key(KEY_HOT2);
      send_key(KEY_HOT3);

      for (int phase = 0; phase < 3; phase++) begin
         tx_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 81 : 0;
         rx_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 24 : 0;
         while (words_sent < WORD_TARGET * (phase + 1) / 3) random_sequence();
         drain_responses();
      end

      repeat (2 * BUF_DEPTH + 8) @(posedge clock);
      if (model.errors == 0 && model.responses_due.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[files.f]
rtl/cle_pkg.sv
rtl/cle_ram.sv
rtl/cle_front.sv
rtl/cle_fifo.sv
rtl/cle_back.sv
rtl/console_line_editor.sv
rtl/cle_checker.sv
dv/tb_console_line_editor.sv
